[rtl/core/rasr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rasr_pkg: shared types for the rational add/subtract/reduce block
// Payload structs, widths and controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package rasr_pkg;

    localparam int IN_W   = 32;
    localparam int NUM_W  = 64;
    localparam int DEN_W  = 62;
    localparam int MAG_W  = 65;   // magnitude of a 64-bit cross-product sum
    localparam int CNT_W  = 7;

    localparam logic [NUM_W-1:0] NUM_MAX = {1'b0, {(NUM_W-1){1'b1}}};
    localparam logic [DEN_W-1:0] DEN_MAX = {DEN_W{1'b1}};

    typedef struct packed {
        logic                    action;
        logic signed [IN_W-1:0]  a_num;
        logic signed [IN_W-1:0]  a_den;
        logic signed [IN_W-1:0]  b_num;
        logic signed [IN_W-1:0]  b_den;
    } in_item_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] res_num;
        logic [DEN_W-1:0]        res_den;
        logic                    den_error;
    } out_item_t;

    // Datapath commands issued by the controller
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,      // capture request
        CMD_MUL,       // form cross products (registered)
        CMD_SUM,       // sign/magnitude sum, denominator magnitude
        CMD_GINIT,     // copy magnitudes into gcd operands
        CMD_GSTEP,     // one binary-gcd step
        CMD_DINIT,     // start division of numerator by gcd
        CMD_DSTEP,     // one restoring-division step
        CMD_DNEXT,     // store quotient, start denominator division
        CMD_FINAL      // saturate and build result
    } cmd_t;

    typedef struct packed {
        logic zero_den;   // an input denominator was zero
        logic zero_num;   // numerator sum is zero
        logic gcd_done;   // a gcd operand reached zero
        logic div_done;   // division counter expired
    } status_t;

endpackage : rasr_pkg
`default_nettype wire

[rtl/core/rasr_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rasr_datapath: arithmetic of the rational add/subtract/reduce block
// Cross products, binary gcd one step a cycle, restoring division by the gcd.
// ----------------------------------------------------------------------------
module rasr_datapath
    import rasr_pkg::*;
(
    input  wire logic      aclk,
    input  wire cmd_t      cmd,
    input  wire in_item_t  req,
    output status_t        status,
    output out_item_t      result
);

    in_item_t                 req_reg;
    logic signed [NUM_W-1:0]  p1_reg, q2_reg, d_reg;
    logic [MAG_W-1:0]         nmag_reg, dmag_reg;
    logic                     neg_reg;
    logic [MAG_W-1:0]         ga_reg, gb_reg;
    logic [CNT_W-1:0]         gk_reg;
    logic [MAG_W-1:0]         rem_reg, quo_reg, dvd_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [MAG_W-1:0]         nq_reg;
    out_item_t                res_reg;

    logic signed [NUM_W-1:0]  prod_ab, prod_ba, prod_dd;
    logic signed [NUM_W:0]    p1x, q2x, sum;
    logic [MAG_W-1:0]         nmag_c, dmag_c, gcd_val, rem_sh, ga_n, gb_n, dsub;
    logic                     gcd_zero_case;

    always_comb begin
        // full 64-bit signed products of the 32-bit fields
        prod_ab = req_reg.a_num * req_reg.b_den;
        prod_ba = req_reg.b_num * req_reg.a_den;
        prod_dd = req_reg.a_den * req_reg.b_den;
        p1x  = {p1_reg[NUM_W-1], p1_reg};
        q2x  = req_reg.action ? -{q2_reg[NUM_W-1], q2_reg} : {q2_reg[NUM_W-1], q2_reg};
        sum  = p1x + q2x;
        nmag_c = sum[NUM_W] ? MAG_W'(-sum) : MAG_W'(sum);
        dmag_c = d_reg[NUM_W-1] ? MAG_W'(-{1'b1, d_reg}) : MAG_W'({1'b0, d_reg});
        // one binary-gcd step: halve both, halve the even one, or subtract
        ga_n = ga_reg;
        gb_n = gb_reg;
        if (!ga_reg[0] && !gb_reg[0]) begin
            ga_n = ga_reg >> 1;
            gb_n = gb_reg >> 1;
        end else if (!ga_reg[0]) begin
            ga_n = ga_reg >> 1;
        end else if (!gb_reg[0]) begin
            gb_n = gb_reg >> 1;
        end else if (ga_reg > gb_reg) begin
            ga_n = gb_reg;
            gb_n = ga_reg - gb_reg;
        end else begin
            gb_n = gb_reg - ga_reg;
        end
        gcd_zero_case = (ga_reg == '0);
        gcd_val = gcd_zero_case ? gb_reg : (ga_reg << gk_reg);
        rem_sh  = {rem_reg[MAG_W-2:0], dvd_reg[MAG_W-1]};
        dsub    = rem_sh - gcd_val;
    end

    always_ff @(posedge aclk) begin
        unique case (cmd)
            CMD_LOAD: req_reg <= req;
            CMD_MUL: begin
                p1_reg <= prod_ab;
                q2_reg <= prod_ba;
                d_reg  <= prod_dd;
            end
            CMD_SUM: begin
                nmag_reg <= nmag_c;
                dmag_reg <= dmag_c;
                neg_reg  <= sum[NUM_W] ^ d_reg[NUM_W-1];
            end
            CMD_GINIT: begin
                ga_reg <= nmag_reg;
                gb_reg <= dmag_reg;
                gk_reg <= '0;
            end
            CMD_GSTEP: begin
                ga_reg <= ga_n;
                gb_reg <= gb_n;
                if (!ga_reg[0] && !gb_reg[0]) gk_reg <= gk_reg + 1'b1;
            end
            CMD_DINIT: begin
                dvd_reg <= nmag_reg;
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= CNT_W'(MAG_W);
            end
            CMD_DSTEP: begin
                dvd_reg <= dvd_reg << 1;
                cnt_reg <= cnt_reg - 1'b1;
                if (rem_sh >= gcd_val) begin
                    rem_reg <= dsub;
                    quo_reg <= {quo_reg[MAG_W-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[MAG_W-2:0], 1'b0};
                end
            end
            CMD_DNEXT: begin
                nq_reg  <= quo_reg;
                dvd_reg <= dmag_reg;
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= CNT_W'(MAG_W);
            end
            CMD_FINAL: begin
                res_reg.den_error <= 1'b0;
                if (req_reg.a_den == '0 || req_reg.b_den == '0 || nmag_reg == '0) begin
                    res_reg.res_num   <= '0;
                    res_reg.res_den   <= DEN_W'(1);
                    res_reg.den_error <= (req_reg.a_den == '0 || req_reg.b_den == '0);
                end else begin
                    if (neg_reg)
                        res_reg.res_num <= NUM_W'(-nq_reg);
                    else if (nq_reg > MAG_W'(NUM_MAX))
                        res_reg.res_num <= NUM_MAX;
                    else
                        res_reg.res_num <= NUM_W'(nq_reg);
                    res_reg.res_den <= (quo_reg > MAG_W'(DEN_MAX)) ? DEN_MAX
                                                                   : DEN_W'(quo_reg);
                end
            end
            default: ;
        endcase
    end

    assign status.zero_den = (req_reg.a_den == '0) || (req_reg.b_den == '0);
    assign status.zero_num = (nmag_reg == '0);
    assign status.gcd_done = (gb_reg == '0) || (ga_reg == '0);
    assign status.div_done = (cnt_reg == '0);
    assign result = res_reg;

endmodule : rasr_datapath
`default_nettype wire

[rtl/core/rasr_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rasr_ctrl: sequencer for the rational add/subtract/reduce block
// Steps the datapath through multiply, gcd and two divisions (skipped on zero input); owns handshakes.
// ----------------------------------------------------------------------------
module rasr_ctrl
    import rasr_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  wire logic    m_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_SUM, ST_CHK, ST_GCD, ST_DIVN, ST_DIVD, ST_FIN, ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = CMD_NONE;
        unique case (state_reg)
            ST_IDLE: if (s_valid) begin
                cmd = CMD_LOAD; state_next = ST_MUL;
            end
            ST_MUL: begin cmd = CMD_MUL; state_next = ST_SUM; end
            ST_SUM: begin cmd = CMD_SUM; state_next = ST_CHK; end
            ST_CHK: begin
                if (status.zero_den || status.zero_num) begin
                    state_next = ST_FIN;
                end else begin
                    cmd = CMD_GINIT; state_next = ST_GCD;
                end
            end
            ST_GCD: begin
                if (status.gcd_done) begin
                    cmd = CMD_DINIT; state_next = ST_DIVN;
                end else begin
                    cmd = CMD_GSTEP;
                end
            end
            ST_DIVN: begin
                if (status.div_done) begin
                    cmd = CMD_DNEXT; state_next = ST_DIVD;
                end else begin
                    cmd = CMD_DSTEP;
                end
            end
            ST_DIVD: begin
                if (status.div_done) state_next = ST_FIN;
                else cmd = CMD_DSTEP;
            end
            ST_FIN: begin
                cmd = CMD_FINAL; state_next = ST_OUT; m_valid_next = 1'b1;
            end
            ST_OUT: if (m_ready) begin
                m_valid_next = 1'b0; state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule : rasr_ctrl
`default_nettype wire

[rtl/core/rational_add_sub_reduce_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rational_add_sub_reduce_top: add or subtract two fractions, lowest terms
// Exact 64-bit cross products, binary gcd, division by gcd, sign on numerator.
// ----------------------------------------------------------------------------
// One request at a time: s_ready is high only while idle. A request passes
// through the product and sum steps, the binary gcd loop (one shift or
// subtract per cycle on 65-bit operands), then restoring division of the
// numerator and denominator by the gcd. A zero denominator or zero numerator
// skips gcd and division and returns 0/1 (den_error set for the zero
// denominator). The result is held in a register until m_ready takes it. No
// state is kept between requests.
module rational_add_sub_reduce_top
    import rasr_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    cmd_t    cmd;
    status_t status;

    // sequencer: handshakes and step control
    rasr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // arithmetic: products, gcd, divisions, result register
    rasr_datapath u_dp (
        .aclk   (aclk),
        .cmd    (cmd),
        .req    (s_data),
        .status (status),
        .result (m_data)
    );

endmodule : rational_add_sub_reduce_top
`default_nettype wire

[rtl/core/rasr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rasr_checker: port-level checks for the rational add/subtract/reduce block
// Watches handshakes and result form on the top level's ports.
// ----------------------------------------------------------------------------
module rasr_checker
    import rasr_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    // result held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one request in flight: no new request while result pending
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("request taken while result pending");

    // denominator always positive
    a_den: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.res_den != '0)
        else $error("zero result denominator");

    // error result is 0/1
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.den_error |-> m_data.res_num == '0 && m_data.res_den == DEN_W'(1))
        else $error("error result not 0/1");

endmodule : rasr_checker

bind rational_add_sub_reduce_top rasr_checker u_rasr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: rational add/subtract/reduce block
// Sends fraction pairs, predicts the reduced sum or difference and checks
// every result field against it, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import rasr_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    out_item_t fraction_q[$];
    int        error_cnt = 0;
    int        sent_cnt = 0;
    int        checked_cnt = 0;
    int        zero_den_cnt = 0;
    bit        calm = 1'b0;   // no idling while set

    rational_add_sub_reduce_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Binary gcd on unsigned magnitudes
    function automatic logic [64:0] gcd_mag(logic [64:0] x, logic [64:0] y);
        int k;
        logic [64:0] t;
        k = 0;
        if (x == 0) return y;
        if (y == 0) return x;
        while (((x | y) & 1) == 0) begin
            x >>= 1; y >>= 1; k++;
        end
        while ((x & 1) == 0) x >>= 1;
        while (y != 0) begin
            while ((y & 1) == 0) y >>= 1;
            if (x > y) begin
                t = x; x = y; y = t;
            end
            y = y - x;
        end
        return x << k;
    endfunction

    // Compute the reduced fraction exactly on wide signed values
    function automatic out_item_t reduce_fraction(in_item_t r);
        out_item_t o;
        logic signed [67:0] an, ad, bn, bd, num, den;
        logic [64:0] nmag, dmag, g;
        bit neg;
        o.res_num = '0; o.res_den = 62'd1; o.den_error = 1'b0;
        an = 68'(r.a_num); ad = 68'(r.a_den); bn = 68'(r.b_num); bd = 68'(r.b_den);
        if (ad == 0 || bd == 0) begin
            o.den_error = 1'b1;
            return o;
        end
        num = r.action ? an * bd - bn * ad : an * bd + bn * ad;
        if (num == 0) return o;
        den = ad * bd;
        neg = (num < 0) ^ (den < 0);
        nmag = (num < 0) ? 65'(-num) : 65'(num);
        dmag = (den < 0) ? 65'(-den) : 65'(den);
        g = gcd_mag(nmag, dmag);
        nmag = nmag / g;
        dmag = dmag / g;
        if (!neg && nmag > 65'h7FFFFFFFFFFFFFFF) nmag = 65'h7FFFFFFFFFFFFFFF;
        if (dmag > 65'h3FFFFFFFFFFFFFFF) dmag = 65'h3FFFFFFFFFFFFFFF;
        o.res_num = neg ? -nmag[63:0] : nmag[63:0];
        o.res_den = dmag[61:0];
        return o;
    endfunction

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 16);
    endfunction

    // Send one request; hold valid and payload until accepted
    task automatic send_request(in_item_t r);
        if (idle_now()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while (idle_now()) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        fraction_q.push_back(reduce_fraction(r));
        sent_cnt++;
        if (r.a_den == 0 || r.b_den == 0) zero_den_cnt++;
    endtask

    // Random result-side stall
    always @(posedge aclk) begin
        if (aresetn) m_ready <= !idle_now();
    end

    // Check each accepted result against the oldest prediction
    always @(posedge aclk) begin
        out_item_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            checked_cnt++;
            if (fraction_q.size() == 0) begin
                $error("unexpected result num=%0d den=%0d", m_data.res_num,
                       m_data.res_den);
                error_cnt++;
            end else begin
                exp_r = fraction_q.pop_front();
                if (m_data.res_num !== exp_r.res_num) begin
                    $error("res_num expected %0d actual %0d", exp_r.res_num,
                           m_data.res_num);
                    error_cnt++;
                end
                if (m_data.res_den !== exp_r.res_den) begin
                    $error("res_den expected %0d actual %0d", exp_r.res_den,
                           m_data.res_den);
                    error_cnt++;
                end
                if (m_data.den_error !== exp_r.den_error) begin
                    $error("den_error expected %0b actual %0b", exp_r.den_error,
                           m_data.den_error);
                    error_cnt++;
                end
            end
        end
    end

    function automatic in_item_t make_req(bit op, int an, int ad, int bn, int bd);
        in_item_t r;
        r.action = op; r.a_num = an; r.a_den = ad; r.b_num = bn; r.b_den = bd;
        return r;
    endfunction

    // Pick a field value: mostly small, sometimes full width or an extreme
    function automatic logic [31:0] pick_field();
        case ($urandom_range(5))
            0, 1: return $urandom_range(40) - 20;
            2:    return $urandom_range(4000) - 2000;
            3:    return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000001;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_extremes();
        int mx, mn;
        mx = 32'h7FFFFFFF; mn = 32'h80000001;
        send_request(make_req(0, 1, 2, 1, 3));
        send_request(make_req(1, 1, 2, 1, 3));
        send_request(make_req(0, mx, mx, mx, mx));
        send_request(make_req(1, mx, 1, mn, 1));
        send_request(make_req(0, mx, 1, mx, 1));
        send_request(make_req(0, mn, 1, mn, 1));
        send_request(make_req(0, 1, mx, 1, mn));
        send_request(make_req(1, mx, mx - 1, mn, mx));
        send_request(make_req(0, 3, -4, 5, 6));
        send_request(make_req(1, -3, -4, -5, -6));
        // Most negative values, handled exactly
        send_request(make_req(0, 32'h80000000, 1, 32'h80000000, 1));
        send_request(make_req(1, 32'h80000000, 32'h80000000, 1, 32'h80000000));
        send_request(make_req(0, 1, 32'h80000000, 1, 32'h7FFFFFFF));
        send_request(make_req(0, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 1));
    endtask

    task automatic test_zero_cases();
        send_request(make_req(0, 5, 0, 3, 7));
        send_request(make_req(1, 5, 7, 3, 0));
        send_request(make_req(0, 0, 0, 0, 0));
        send_request(make_req(0, 0, 9, 0, -4));
        send_request(make_req(1, 2, 3, 2, 3));
        send_request(make_req(0, 2, 3, -4, 6));
    endtask

    task automatic test_random(int n);
        in_item_t r;
        repeat (n) begin
            r.action = $urandom_range(1);
            r.a_num = pick_field(); r.a_den = pick_field();
            r.b_num = pick_field(); r.b_den = pick_field();
            // Mostly nonzero denominators so the gcd path gets exercised
            if (r.a_den == 0 && $urandom_range(3) != 0) r.a_den = 1;
            if (r.b_den == 0 && $urandom_range(3) != 0) r.b_den = -1;
            send_request(r);
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_zero_cases();
        test_random(900);
        calm = 1'b1;            // a long stretch without idling
        test_random(300);
        calm = 1'b0;
        test_random(600);
        s_valid <= 1'b0;
        // Drain: wait for outstanding results, then some margin
        while (fraction_q.size() != 0) @(posedge aclk);
        repeat (500) @(posedge aclk);
        $display("Sent %0d requests (%0d with a zero denominator), checked %0d results.",
                 sent_cnt, zero_den_cnt, checked_cnt);
        if (error_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Generous time limit for all 1820 requests
    initial begin
        #100ms;
        $display("Timeout after %0d results", checked_cnt);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
rtl/core/rasr_pkg.sv
rtl/core/rasr_datapath.sv
rtl/core/rasr_ctrl.sv
rtl/core/rational_add_sub_reduce_top.sv
rtl/core/rasr_checker.sv
sim/testbench.sv
